// File: rtl/hws_pkg.sv
// Haptic waveform sequencer package: transaction payload types, controller and
// datapath interface structs, function and register codes, gain constants.
// No dependencies.
`timescale 1ns / 1ps

package hws_pkg;

	localparam int MAX_ENTRIES_DEF = 32;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 6;

	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_FROM    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_INTENSITY      = 2'd2;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;
	localparam logic [1:0] FUNC_STOP  = 2'd3;

	localparam logic [1:0] INTENSITY_OFF  = 2'd0;
	localparam logic [1:0] INTENSITY_LOW  = 2'd1;
	localparam logic [1:0] INTENSITY_MED  = 2'd2;
	localparam logic [1:0] INTENSITY_HIGH = 2'd3;

	localparam logic [14:0] GAIN_LOW   = 15'd16383;
	localparam logic [14:0] GAIN_RESET = 15'h7fff;

	typedef struct packed {
		logic [1:0]  func;
		logic [4:0]  entry_index;
		logic [15:0] entry_duration_ms;
		logic [7:0]  entry_amplitude;
	} item_t;

	typedef struct packed {
		logic        drive_on;
		logic [14:0] drive_magnitude;
		logic        playing;
		logic [4:0]  entry_now;
		logic [15:0] remaining_ms;
		logic        refused;
	} result_t;

	typedef struct packed {
		logic accept;
		logic wr_entry;
		logic refuse;
		logic halt;
		logic scan_init;
		logic keep_set;
		logic ptr_inc;
		logic adv_init;
		logic tick_dec;
		logic tick_adv;
		logic jump;
		logic visit;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic intensity_off;
		logic repeat_neg;
		logic active;
		logic time_zero;
		logic ptr_in_range;
		logic scan_hit;
		logic dur_nonzero;
		logic loop_valid;
		logic steps_done;
	} dp_status_t;

endpackage

// File: rtl/hws_ctrl.sv
// Haptic waveform sequencer controller: transaction handshakes and the state
// machine that sequences the datapath. Depends on hws_pkg.
`timescale 1ns / 1ps

module hws_ctrl import hws_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [1:0] func,
	output logic       result_valid,
	input  logic       result_ready,
	output dp_cmd_t    cmd,
	input  dp_status_t st
);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_TICK      = 3'd1;
	localparam logic [2:0] ST_SCAN      = 3'd2;
	localparam logic [2:0] ST_SCAN_EV   = 3'd3;
	localparam logic [2:0] ST_ADV_START = 3'd4;
	localparam logic [2:0] ST_ADV       = 3'd5;
	localparam logic [2:0] ST_EVAL      = 3'd6;
	localparam logic [2:0] ST_FINISH    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.accept = 1'b1;
					unique case (func)
						FUNC_WRITE: begin
							cmd.wr_entry = 1'b1;
							state_nxt    = ST_FINISH;
						end
						FUNC_START: begin
							if (st.intensity_off) begin
								cmd.refuse = 1'b1;
								state_nxt  = ST_FINISH;
							end else begin
								cmd.scan_init = 1'b1;
								state_nxt     = st.repeat_neg ? ST_ADV_START : ST_SCAN;
							end
						end
						FUNC_TICK: begin
							if (st.active) begin
								cmd.tick_dec = 1'b1;
								state_nxt    = ST_TICK;
							end else begin
								state_nxt = ST_FINISH;
							end
						end
						FUNC_STOP: begin
							cmd.halt  = 1'b1;
							state_nxt = ST_FINISH;
						end
						default: state_nxt = ST_FINISH;
					endcase
				end
			end
			ST_TICK: begin
				if (st.time_zero) begin
					cmd.tick_adv = 1'b1;
					state_nxt    = ST_ADV;
				end else begin
					state_nxt = ST_FINISH;
				end
			end
			ST_SCAN: begin
				state_nxt = st.ptr_in_range ? ST_SCAN_EV : ST_ADV_START;
			end
			ST_SCAN_EV: begin
				if (st.scan_hit) begin
					cmd.keep_set = 1'b1;
					state_nxt    = ST_ADV_START;
				end else begin
					cmd.ptr_inc = 1'b1;
					state_nxt   = ST_SCAN;
				end
			end
			ST_ADV_START: begin
				cmd.adv_init = 1'b1;
				state_nxt    = ST_ADV;
			end
			ST_ADV: begin
				if (st.steps_done) begin
					cmd.halt  = 1'b1;
					state_nxt = ST_FINISH;
				end else if (st.ptr_in_range) begin
					state_nxt = ST_EVAL;
				end else if (!st.loop_valid) begin
					cmd.halt  = 1'b1;
					state_nxt = ST_FINISH;
				end else begin
					cmd.jump = 1'b1;
				end
			end
			ST_EVAL: begin
				cmd.visit = 1'b1;
				state_nxt = st.dur_nonzero ? ST_FINISH : ST_ADV;
			end
			ST_FINISH: begin
				if (!out_valid_q || result_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/hws_dp.sv
// Haptic waveform sequencer datapath: pattern memory, configuration registers,
// play state, amplitude scaling and gain, result register. Depends on hws_pkg.
`timescale 1ns / 1ps

module hws_dp import hws_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  item_t                  item,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  dp_cmd_t                cmd,
	output dp_status_t             st,
	output result_t                result
);

	localparam int AW  = $clog2(MAX_ENTRIES);
	localparam int NW  = $clog2(MAX_ENTRIES + 1);
	localparam int CW  = (NW > 6) ? NW : 6;
	localparam int SW  = $clog2(2 * MAX_ENTRIES + 5);
	localparam int MAX_STEPS = 2 * MAX_ENTRIES + 4;

	function automatic logic [7:0] scale_amp(input logic [1:0] inten, input logic [7:0] a);
		logic [9:0]  x;
		logic [17:0] p;
		logic [7:0]  s;
		x = {1'b0, a, 1'b0} + 10'(a);
		p = 18'(x) * 18'd205;
		case (inten)
			INTENSITY_LOW:  s = p[18-1:11] == 7'd0 ? 8'd0 : 8'(p[17:11]);
			INTENSITY_MED:  s = p[17:10];
			INTENSITY_HIGH: s = a;
			default:        s = 8'd255;
		endcase
		return s;
	endfunction

	function automatic logic [14:0] gain_of(input logic [7:0] s);
		logic [15:0] y;
		logic [15:0] q;
		y = {2'b00, s, 6'b000000};
		q = (y + 16'd1 + (y >> 8)) >> 8;
		return GAIN_LOW + y[14:0] + q[14:0];
	endfunction

	logic [23:0]     mem [MAX_ENTRIES];
	logic [15:0]     rd_dur_q;
	logic [7:0]      rd_amp_q;

	logic [5:0]      pattern_length_q;
	logic [5:0]      repeat_from_q;
	logic [1:0]      intensity_q;

	logic [CW-1:0]   ptr_q;
	logic [CW-1:0]   loop_idx_q;
	logic            loop_valid_q;
	logic            keep_q;
	logic [SW-1:0]   steps_q;
	logic [AW-1:0]   pos_q;
	logic [15:0]     time_q;
	logic            active_q;
	logic            motor_q;
	logic [14:0]     gain_q;
	logic            refused_q;
	result_t         result_q;

	logic [CW-1:0]   used_len;
	logic [7:0]      scaled;
	logic            wr_ok;

	assign used_len = (CW'(pattern_length_q) > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
		: CW'(pattern_length_q);
	assign scaled   = scale_amp(intensity_q, rd_amp_q);
	assign wr_ok    = CW'(item.entry_index) < CW'(MAX_ENTRIES);

	assign st.intensity_off = (intensity_q == INTENSITY_OFF);
	assign st.repeat_neg    = repeat_from_q[5];
	assign st.active        = active_q;
	assign st.time_zero     = (time_q == 16'd0);
	assign st.ptr_in_range  = (ptr_q < used_len);
	assign st.scan_hit      = (rd_dur_q != 16'd0) && (rd_amp_q != 8'd0);
	assign st.dur_nonzero   = (rd_dur_q != 16'd0);
	assign st.loop_valid    = loop_valid_q;
	assign st.steps_done    = (steps_q == SW'(MAX_STEPS));

	assign result = result_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_entry && wr_ok) begin
			mem[AW'(item.entry_index)] <= {item.entry_duration_ms, item.entry_amplitude};
		end
		{rd_dur_q, rd_amp_q} <= mem[ptr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= '0;
			repeat_from_q    <= '1;
			intensity_q      <= INTENSITY_OFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_wdata;
				REG_REPEAT_FROM:    repeat_from_q    <= cfg_wdata;
				REG_INTENSITY:      intensity_q      <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			loop_idx_q   <= '0;
			loop_valid_q <= 1'b0;
			keep_q       <= 1'b0;
			steps_q      <= '0;
			pos_q        <= '0;
			time_q       <= '0;
			active_q     <= 1'b0;
			motor_q      <= 1'b0;
			gain_q       <= GAIN_RESET;
			refused_q    <= 1'b0;
		end else begin
			if (cmd.accept) begin
				refused_q <= cmd.refuse;
			end
			if (cmd.refuse || cmd.halt) begin
				active_q <= 1'b0;
				motor_q  <= 1'b0;
				time_q   <= '0;
			end
			if (cmd.refuse) begin
				pos_q <= '0;
			end
			if (cmd.scan_init) begin
				ptr_q  <= CW'(repeat_from_q[4:0]);
				keep_q <= 1'b0;
			end
			if (cmd.keep_set) begin
				keep_q <= 1'b1;
			end
			if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.adv_init) begin
				ptr_q        <= '0;
				steps_q      <= '0;
				active_q     <= 1'b1;
				loop_valid_q <= keep_q;
				loop_idx_q   <= CW'(repeat_from_q[4:0]);
			end
			if (cmd.tick_dec && time_q != 16'd0) begin
				time_q <= time_q - 16'd1;
			end
			if (cmd.tick_adv) begin
				ptr_q   <= CW'(pos_q) + 1'b1;
				steps_q <= '0;
			end
			if (cmd.jump) begin
				ptr_q   <= loop_idx_q;
				steps_q <= steps_q + 1'b1;
			end
			if (cmd.visit) begin
				pos_q   <= ptr_q[AW-1:0];
				steps_q <= steps_q + 1'b1;
				if (rd_dur_q != 16'd0) begin
					time_q <= rd_dur_q;
					if (scaled != 8'd0) begin
						motor_q <= 1'b1;
						gain_q  <= gain_of(scaled);
					end else begin
						motor_q <= 1'b0;
					end
				end else begin
					motor_q <= 1'b0;
					ptr_q   <= ptr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q.drive_on        <= motor_q;
			result_q.drive_magnitude <= gain_q;
			result_q.playing         <= active_q;
			result_q.entry_now       <= 5'(pos_q);
			result_q.remaining_ms    <= active_q ? time_q : 16'd0;
			result_q.refused         <= refused_q;
		end
	end

endmodule

// File: rtl/haptic_waveform_sequencer_core.sv
// Haptic waveform sequencer top level: joins the controller and the datapath.
// Depends on hws_pkg, hws_ctrl and hws_dp.
//
// Usage: items (write entry, start, 1 ms tick, stop) arrive on the item
// valid/ready channel; each accepted item yields exactly one result on the
// result valid/ready channel, carrying drive state, gain, playing flag,
// current entry, remaining time and the start-refused flag.
// Configuration (pattern length, repeat point, intensity) is written through
// cfg_we/cfg_index/cfg_wdata with no wait; the user must write it only while
// no item is in flight, as the block does not enforce this. Write, stop,
// refused start and idle tick go straight to the result; a tick that does not
// end an entry passes through the tick state first. A start with a repeat
// point scans from it to the first sounding entry, then advances; an advance
// visits entries in order, jumping back to the repeat point past the end, at
// most 2*MAX_ENTRIES+4 steps. The pattern memory has one registered read port.
// One item is processed at a time; a new item is accepted once the previous
// result is in the output register, even if that result is not yet taken.
// A stalled receiver holds the result; the next result waits behind it.
// Reset: not playing, drive off, gain 32767, length 0, no repeat point,
// intensity off. Pattern memory content is undefined until written.
`timescale 1ns / 1ps

module haptic_waveform_sequencer_core import hws_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  item_t                  item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output result_t                result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	dp_cmd_t    cmd;
	dp_status_t st;

	hws_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.func         (item.func),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd),
		.st           (st)
	);

	hws_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.st        (st),
		.result    (result)
	);

endmodule

// File: rtl/hws_checker.sv
// Haptic waveform sequencer port checker and its bind to the top level.
// Depends on hws_pkg and haptic_waveform_sequencer_core.
`timescale 1ns / 1ps

module hws_checker import hws_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_refused_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.refused |-> !result.playing && !result.drive_on)
		else $error("refused start left playback running");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.playing |-> result.remaining_ms == 16'd0 && !result.drive_on)
		else $error("stopped sequencer shows time or drive");

	a_play_time: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.playing |-> result.remaining_ms != 16'd0)
		else $error("playing entry with no time left");

	a_drive_gain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.drive_on |-> result.drive_magnitude >= GAIN_LOW)
		else $error("drive on with gain below floor");

endmodule

bind haptic_waveform_sequencer_core hws_checker u_hws_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
